FILE: design/maze_room_merge_kruskal_macros.svh
// assertion helpers for the room merge block
`ifndef MAZE_ROOM_MERGE_KRUSKAL_MACROS_SVH
`define MAZE_ROOM_MERGE_KRUSKAL_MACROS_SVH

// same-cycle implication
`define MRK_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("maze_room_merge_kruskal: check failed");

// next-cycle implication
`define MRK_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("maze_room_merge_kruskal: check failed");

`endif

FILE: design/mrk_pkg.sv
package mrk_pkg;

  typedef enum logic [1:0] {K_RESTART, K_PASS, K_OUTSIDE} kind_e;

  typedef enum logic [1:0] {
    ST_JOINED    = 2'd0,
    ST_NO_DIR    = 2'd1,
    ST_OUTSIDE   = 2'd2,
    ST_RESTARTED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_READ, B_WAIT, B_EVAL, B_MOD, B_SCAN, B_PICK, B_MERGE, B_RESULT
  } bstate_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [15:0] rnd;
  } job_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  dir;
    logic [7:0]  n1;
    logic [7:0]  n2;
    logic [7:0]  n3;
    logic        diag;
    logic [8:0]  rooms;
    logic        done;
    logic [15:0] passes;
    logic [15:0] fails;
  } res_t;

  typedef struct packed {
    logic q_full;
    logic init_busy;
  } front_ctl_t;

  localparam int DIRS = 12;

  // offsets coded 0,1,2 for -1,0,+1
  localparam logic [1:0] SIDE_X [DIRS] = '{2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2,
                                          2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
  localparam logic [1:0] SIDE_Y [DIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                          2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1};
  localparam logic [1:0] CORN_X [DIRS] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2,
                                          2'd2, 2'd1, 2'd0, 2'd0, 2'd1, 2'd0};
  localparam logic [1:0] CORN_Y [DIRS] = '{2'd0, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2,
                                          2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0};
  localparam logic [DIRS-1:0] DIAG_DIR = 12'b1011_0110_1101;

  localparam logic CFG_GRID_SIZE       = 1'b0;
  localparam logic CFG_ENABLE_DIAGONAL = 1'b1;

endpackage

FILE: design/mrk_front.sv
module mrk_front import mrk_pkg::*; #(
  parameter int GRID_MAX = 16,
  localparam int NW = $clog2(GRID_MAX + 1)
) (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          command_i,
  input  logic [3:0]    cell_x_i,
  input  logic [3:0]    cell_y_i,
  input  logic [15:0]   random_word_i,
  input  logic [NW-1:0] n_i,
  input  front_ctl_t    ctl_i,
  output logic          push_o,
  output job_t          job_o
);

  logic cell_ok;

  assign cell_ok    = (8'(cell_x_i) < 8'(n_i)) && (8'(cell_y_i) < 8'(n_i));
  assign in_stall_o = ctl_i.q_full || ctl_i.init_busy;
  assign push_o     = in_valid_i && !in_stall_o;

  always_comb begin
    job_o.x   = cell_x_i;
    job_o.y   = cell_y_i;
    job_o.rnd = random_word_i;
    if (!command_i) begin
      job_o.kind = K_RESTART;
    end else if (cell_ok) begin
      job_o.kind = K_PASS;
    end else begin
      job_o.kind = K_OUTSIDE;
    end
  end

endmodule

FILE: design/mrk_queue.sv
module mrk_queue import mrk_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t       ent_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = !wp_q;
    end
    if (pop_i) begin
      rp_d = !rp_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= job_i;
    end
  end

  assign job_o   = ent_q[rp_q];
  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;

endmodule

FILE: design/mrk_back.sv
module mrk_back import mrk_pkg::*; #(
  parameter int GRID_MAX = 16,
  localparam int NW = $clog2(GRID_MAX + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [NW-1:0] n_i,
  input  logic          diag_en_i,
  input  logic          q_empty_i,
  input  job_t          q_job_i,
  output logic          q_pop_o,
  output logic          init_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output res_t          out_res_o
);

  localparam int AW    = $clog2(GRID_MAX);
  localparam int CW    = ((AW > 4) ? AW : 4) + 1;
  localparam int LW    = $clog2(GRID_MAX * GRID_MAX);
  localparam int RW    = $clog2(GRID_MAX * GRID_MAX + 1);
  localparam int RST_N = (GRID_MAX < 4) ? GRID_MAX : 4;
  localparam int DEPTH = 1 << (2 * AW);

  bstate_e         st_q, st_d;
  logic            init_q, init_d;
  job_t            job_q, job_d;
  logic [AW-1:0]   i_q, i_d, j_q, j_d;
  logic [LW-1:0]   base_q, base_d;
  logic [NW-1:0]   sn_q, sn_d;
  logic [1:0]      ox_q, ox_d, oy_q, oy_d;
  logic            cap_v_q, cap_v_d;
  logic [1:0]      cap_x_q, cap_x_d, cap_y_q, cap_y_d;
  logic [LW-1:0]   lab_q [3][3];
  logic [LW-1:0]   lab_d [3][3];
  logic [DIRS-1:0] legal_q, legal_d;
  logic [3:0]      cnt_q, cnt_d, rem_q, rem_d, bit_q, bit_d;
  logic [3:0]      rank_q, rank_d, d_q, d_d, sel_q, sel_d;
  logic [15:0]     rnd_q, rnd_d;
  logic [LW-1:0]   r1_q, r1_d, r2_q, r2_d, r3_q, r3_d;
  logic            mv_q, mv_d;
  logic [2*AW-1:0] ma_q, ma_d;
  logic [RW-1:0]   room_q, room_d;
  logic [15:0]     pass_q, pass_d, fail_q, fail_d;
  status_e         status_q, status_d;
  logic [7:0]      n1_q, n1_d, n2_q, n2_d, n3_q, n3_d;
  logic            diag_q, diag_d;
  res_t            out_q, out_d;
  logic            out_v_q, out_v_d;

  logic [LW-1:0]   mem [DEPTH];
  logic [LW-1:0]   rdata_q;
  logic            we;
  logic [2*AW-1:0] wa, ra;
  logic [LW-1:0]   wd;

  logic [CW-1:0]   x_c, y_c, xx, yy, sx, sy, cx, cy;
  logic            inb [3][3];
  logic [DIRS-1:0] legal_c;
  logic [3:0]      cnt_c;
  logic [4:0]      rem5;
  logic            in_grid;
  logic [31:0]     room32;
  res_t            res;

  assign x_c = CW'(job_q.x);
  assign y_c = CW'(job_q.y);
  assign xx  = x_c + CW'(ox_q) - CW'(1);
  assign yy  = y_c + CW'(oy_q) - CW'(1);
  assign sx  = x_c + CW'(SIDE_X[sel_q]) - CW'(1);
  assign sy  = y_c + CW'(SIDE_Y[sel_q]) - CW'(1);
  assign cx  = x_c + CW'(CORN_X[sel_q]) - CW'(1);
  assign cy  = y_c + CW'(CORN_Y[sel_q]) - CW'(1);

  always_comb begin
    logic [CW-1:0] px, py;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        px        = x_c + CW'(a) - CW'(1);
        py        = y_c + CW'(b) - CW'(1);
        inb[a][b] = (px < CW'(n_i)) && (py < CW'(n_i));
      end
    end
  end

  // legality of the twelve directions from the captured neighborhood
  always_comb begin
    logic [LW-1:0] la, lb, lc;
    logic          si, ci;
    cnt_c = 4'd0;
    for (int d = 0; d < DIRS; d++) begin
      la = lab_q[1][1];
      lb = lab_q[SIDE_X[d]][SIDE_Y[d]];
      lc = lab_q[CORN_X[d]][CORN_Y[d]];
      si = inb[SIDE_X[d]][SIDE_Y[d]];
      ci = inb[CORN_X[d]][CORN_Y[d]];
      if (DIAG_DIR[d]) begin
        legal_c[d] = diag_en_i && si && ci && (la != lb) && (lb != lc) && (lc != la);
      end else begin
        legal_c[d] = si && (la != lb);
      end
      cnt_c = cnt_c + 4'(legal_c[d]);
    end
  end

  assign rem5    = {rem_q, rnd_q[15]};
  assign in_grid = (8'(i_q) < 8'(sn_q)) && (8'(j_q) < 8'(sn_q));
  assign room32  = 32'(room_q);

  always_comb begin
    res.status = status_q;
    res.dir    = sel_q;
    res.n1     = n1_q;
    res.n2     = n2_q;
    res.n3     = n3_q;
    res.diag   = diag_q;
    res.rooms  = room32[8:0];
    res.done   = room_q == RW'(1);
    res.passes = pass_q;
    res.fails  = fail_q;
  end

  always_comb begin
    st_d     = st_q;
    init_d   = init_q;
    job_d    = job_q;
    i_d      = i_q;
    j_d      = j_q;
    base_d   = base_q;
    sn_d     = sn_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    cap_v_d  = 1'b0;
    cap_x_d  = cap_x_q;
    cap_y_d  = cap_y_q;
    lab_d    = lab_q;
    legal_d  = legal_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    bit_d    = bit_q;
    rank_d   = rank_q;
    d_d      = d_q;
    sel_d    = sel_q;
    rnd_d    = rnd_q;
    r1_d     = r1_q;
    r2_d     = r2_q;
    r3_d     = r3_q;
    mv_d     = 1'b0;
    ma_d     = ma_q;
    room_d   = room_q;
    pass_d   = pass_q;
    fail_d   = fail_q;
    status_d = status_q;
    n1_d     = n1_q;
    n2_d     = n2_q;
    n3_d     = n3_q;
    diag_d   = diag_q;
    out_d    = out_q;
    out_v_d  = out_v_q && out_stall_i;
    q_pop_o  = 1'b0;
    we       = 1'b0;
    wa       = {i_q, j_q};
    wd       = r1_q;
    ra       = {i_q, j_q};

    if (cap_v_q) begin
      lab_d[cap_x_q][cap_y_q] = rdata_q;
    end
    if (mv_q && (rdata_q == r2_q || rdata_q == r3_q)) begin
      we = 1'b1;
      wa = ma_q;
      wd = r1_q;
    end

    case (st_q)
      B_CLEAR: begin
        we = 1'b1;
        wa = {i_q, j_q};
        wd = in_grid ? base_q + LW'(j_q) : '0;
        if (j_q == AW'(GRID_MAX - 1)) begin
          j_d = '0;
          i_d = i_q + AW'(1);
          if (8'(i_q) < 8'(sn_q)) begin
            base_d = base_q + LW'(sn_q);
          end
          if (i_q == AW'(GRID_MAX - 1)) begin
            init_d = 1'b0;
            st_d   = init_q ? B_IDLE : B_RESULT;
          end
        end else begin
          j_d = j_q + AW'(1);
        end
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o  = 1'b1;
          job_d    = q_job_i;
          sel_d    = '0;
          n1_d     = '0;
          n2_d     = '0;
          n3_d     = '0;
          diag_d   = 1'b0;
          i_d      = '0;
          j_d      = '0;
          case (q_job_i.kind)
            K_RESTART: begin
              sn_d     = n_i;
              base_d   = '0;
              room_d   = RW'(16'(n_i) * 16'(n_i));
              pass_d   = '0;
              fail_d   = '0;
              status_d = ST_RESTARTED;
              st_d     = B_CLEAR;
            end
            K_PASS: begin
              if (pass_q != 16'hFFFF) pass_d = pass_q + 16'd1;
              n1_d = 8'(16'(q_job_i.x) * 16'(n_i) + 16'(q_job_i.y));
              ox_d = 2'd0;
              oy_d = 2'd0;
              st_d = B_READ;
            end
            default: begin
              if (pass_q != 16'hFFFF) pass_d = pass_q + 16'd1;
              status_d = ST_OUTSIDE;
              st_d     = B_RESULT;
            end
          endcase
        end
      end
      B_READ: begin
        ra      = {xx[AW-1:0], yy[AW-1:0]};
        cap_v_d = 1'b1;
        cap_x_d = ox_q;
        cap_y_d = oy_q;
        if (oy_q == 2'd2) begin
          oy_d = 2'd0;
          ox_d = ox_q + 2'd1;
          if (ox_q == 2'd2) st_d = B_WAIT;
        end else begin
          oy_d = oy_q + 2'd1;
        end
      end
      B_WAIT: begin
        st_d = B_EVAL;
      end
      B_EVAL: begin
        legal_d = legal_c;
        cnt_d   = cnt_c;
        if (cnt_c == 4'd0) begin
          if (fail_q != 16'hFFFF) fail_d = fail_q + 16'd1;
          status_d = ST_NO_DIR;
          st_d     = B_RESULT;
        end else begin
          rem_d = '0;
          bit_d = '0;
          rnd_d = job_q.rnd;
          st_d  = B_MOD;
        end
      end
      B_MOD: begin
        // restoring remainder, one bit per cycle
        rem_d = (rem5 >= 5'(cnt_q)) ? 4'(rem5 - 5'(cnt_q)) : rem5[3:0];
        rnd_d = {rnd_q[14:0], 1'b0};
        bit_d = bit_q + 4'd1;
        if (bit_q == 4'd15) begin
          d_d    = '0;
          rank_d = '0;
          st_d   = B_SCAN;
        end
      end
      B_SCAN: begin
        d_d = d_q + 4'd1;
        if (legal_q[d_q]) begin
          rank_d = rank_q + 4'd1;
          if (rank_q == rem_q) begin
            sel_d = d_q;
            st_d  = B_PICK;
          end
        end
      end
      B_PICK: begin
        r1_d     = lab_q[1][1];
        r2_d     = lab_q[SIDE_X[sel_q]][SIDE_Y[sel_q]];
        n2_d     = 8'(16'(sx) * 16'(n_i) + 16'(sy));
        status_d = ST_JOINED;
        if (DIAG_DIR[sel_q]) begin
          r3_d   = lab_q[CORN_X[sel_q]][CORN_Y[sel_q]];
          n3_d   = 8'(16'(cx) * 16'(n_i) + 16'(cy));
          diag_d = 1'b1;
          room_d = (room_q > RW'(3)) ? room_q - RW'(2) : RW'(1);
        end else begin
          r3_d   = lab_q[SIDE_X[sel_q]][SIDE_Y[sel_q]];
          room_d = (room_q > RW'(2)) ? room_q - RW'(1) : RW'(1);
        end
        i_d  = '0;
        j_d  = '0;
        st_d = B_MERGE;
      end
      B_MERGE: begin
        ra   = {i_q, j_q};
        mv_d = 1'b1;
        ma_d = {i_q, j_q};
        if (8'(j_q) == 8'(n_i) - 8'd1) begin
          j_d = '0;
          i_d = i_q + AW'(1);
          if (8'(i_q) == 8'(n_i) - 8'd1) st_d = B_RESULT;
        end else begin
          j_d = j_q + AW'(1);
        end
      end
      B_RESULT: begin
        if (!out_v_q || !out_stall_i) begin
          out_d   = res;
          out_v_d = 1'b1;
          st_d    = B_IDLE;
        end
      end
      default: begin
        st_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= B_CLEAR;
      init_q  <= 1'b1;
      i_q     <= '0;
      j_q     <= '0;
      base_q  <= '0;
      sn_q    <= NW'(RST_N);
      cap_v_q <= 1'b0;
      mv_q    <= 1'b0;
      room_q  <= RW'(RST_N * RST_N);
      pass_q  <= '0;
      fail_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      init_q  <= init_d;
      i_q     <= i_d;
      j_q     <= j_d;
      base_q  <= base_d;
      sn_q    <= sn_d;
      cap_v_q <= cap_v_d;
      mv_q    <= mv_d;
      room_q  <= room_d;
      pass_q  <= pass_d;
      fail_q  <= fail_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    cap_x_q  <= cap_x_d;
    cap_y_q  <= cap_y_d;
    lab_q    <= lab_d;
    legal_q  <= legal_d;
    cnt_q    <= cnt_d;
    rem_q    <= rem_d;
    bit_q    <= bit_d;
    rank_q   <= rank_d;
    d_q      <= d_d;
    sel_q    <= sel_d;
    rnd_q    <= rnd_d;
    r1_q     <= r1_d;
    r2_q     <= r2_d;
    r3_q     <= r3_d;
    ma_q     <= ma_d;
    status_q <= status_d;
    n1_q     <= n1_d;
    n2_q     <= n2_d;
    n3_q     <= n3_d;
    diag_q   <= diag_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[ra];
  end

  assign init_o      = init_q;
  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

endmodule

FILE: design/maze_room_merge_kruskal.sv
// Room-merging maze builder on a square grid of up to GRID_MAX by GRID_MAX cells, with the
// room label of every cell held in a label memory with one read and one write port. A
// pass word runs nine label reads, a remainder of its 16-bit random word, a scan of up to
// twelve directions, then a relabel of the grid cell by cell; a word outside the grid or
// with no legal direction returns its result without relabelling. A restart word sweeps
// all GRID_MAX*GRID_MAX label entries. After reset the same sweep runs with a side of
// 4, or GRID_MAX if smaller, while the input is stalled; configuration writes are
// taken meanwhile. A two-word queue sits in front of the merge engine, and one output
// register holds the result, so new words are taken while a result waits.
`include "maze_room_merge_kruskal_macros.svh"

module maze_room_merge_kruskal import mrk_pkg::*; #(
  parameter int GRID_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [3:0]  cell_x_i,
  input  logic [3:0]  cell_y_i,
  input  logic [15:0] random_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  direction_o,
  output logic [7:0]  first_node_o,
  output logic [7:0]  second_node_o,
  output logic [7:0]  third_node_o,
  output logic        diagonal_o,
  output logic [8:0]  rooms_left_o,
  output logic        done_res_o,
  output logic [15:0] pass_count_o,
  output logic [15:0] failed_count_o
);

  localparam int NW = $clog2(GRID_MAX + 1);

  logic [4:0]    grid_q;
  logic          diag_en_q;
  logic [NW-1:0] n;
  front_ctl_t    fctl;
  logic          push, pop, q_full, q_empty, init_busy;
  job_t          push_job, head_job;
  res_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q    <= 5'd4;
      diag_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GRID_SIZE:       grid_q    <= cfg_data_i;
        CFG_ENABLE_DIAGONAL: diag_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // side length clamped to the built range
  always_comb begin
    if (32'(grid_q) < 32'd2) begin
      n = NW'(2);
    end else if (32'(grid_q) > 32'(GRID_MAX)) begin
      n = NW'(GRID_MAX);
    end else begin
      n = NW'(grid_q);
    end
  end

  assign fctl.q_full    = q_full;
  assign fctl.init_busy = init_busy;

  mrk_front #(.GRID_MAX(GRID_MAX)) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .random_word_i (random_word_i),
    .n_i           (n),
    .ctl_i         (fctl),
    .push_o        (push),
    .job_o         (push_job)
  );

  mrk_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mrk_back #(.GRID_MAX(GRID_MAX)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n),
    .diag_en_i   (diag_en_q),
    .q_empty_i   (q_empty),
    .q_job_i     (head_job),
    .q_pop_o     (pop),
    .init_o      (init_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res)
  );

  assign status_o       = res.status;
  assign direction_o    = res.dir;
  assign first_node_o   = res.n1;
  assign second_node_o  = res.n2;
  assign third_node_o   = res.n3;
  assign diagonal_o     = res.diag;
  assign rooms_left_o   = res.rooms;
  assign done_res_o     = res.done;
  assign pass_count_o   = res.passes;
  assign failed_count_o = res.fails;

  `MRK_ASSERT_IMP(a_full_stalls, q_full, in_stall_o)
  `MRK_ASSERT_IMP(a_restart_clears, out_valid_o && status_o == ST_RESTARTED, pass_count_o == 16'd0 && failed_count_o == 16'd0)
  `MRK_ASSERT_IMP(a_fails_bounded, out_valid_o, failed_count_o <= pass_count_o)
  `MRK_ASSERT_IMP(a_diag_dir, out_valid_o && status_o == ST_JOINED, diagonal_o == DIAG_DIR[direction_o])
  `MRK_ASSERT_NXT(a_pop_nonempty, pop, !init_busy)

endmodule
